/* sv/ray_sphere_intersection_core_defines.svh */
// Assertion macros used by the ray-sphere intersection back pipeline.
`ifndef RAY_SPHERE_INTERSECTION_CORE_DEFINES_SVH
`define RAY_SPHERE_INTERSECTION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rsi_pkg.sv */
// Types and constants shared by the ray-sphere intersection pipeline.
package rsi_pkg;

  localparam int SQRT_BITS = 28;
  localparam int REM_W     = 2 * SQRT_BITS;
  localparam int TCA_W     = 29;

  typedef enum logic [1:0] {
    REG_CENTER_X      = 2'd0,
    REG_CENTER_Y      = 2'd1,
    REG_CENTER_Z      = 2'd2,
    REG_SPHERE_RADIUS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic        [24:0] distance;
  } ray_out_t;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic        [22:0] sphere_radius;
  } cfg_t;

  typedef struct packed {
    ray_in_t                  ray;
    logic signed [TCA_W-1:0]  tca;
    logic                     miss;
  } mid_t;

  typedef struct packed {
    mid_t             mid;
    logic [REM_W-1:0] rem;
  } front_out_t;

  typedef struct packed {
    mid_t                 mid;
    logic [SQRT_BITS-1:0] thc;
  } sqrt_out_t;

endpackage

/* sv/rsi_front.sv */
// Front pipeline: L vector, dot products, tca rounding, d2 and the miss test.
module rsi_front (
  input  logic                clk,
  input  logic                rst,
  input  rsi_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsi_pkg::ray_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsi_pkg::front_out_t out_data
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1
  rsi_pkg::ray_in_t   ray1;
  logic signed [24:0] lx, ly, lz;
  logic        [22:0] rad1;
  // stage 2
  rsi_pkg::ray_in_t   ray2;
  logic signed [40:0] pdx, pdy, pdz;
  logic signed [49:0] plx, ply, plz;
  logic        [45:0] r2_2;
  // stage 3
  rsi_pkg::ray_in_t   ray3;
  logic signed [rsi_pkg::TCA_W-1:0] tca3;
  logic        [51:0] ll3;
  logic        [45:0] r2_3;
  // stage 4
  rsi_pkg::ray_in_t   ray4;
  logic signed [rsi_pkg::TCA_W-1:0] tca4;
  logic signed [57:0] tca2;
  logic        [51:0] ll4;
  logic        [45:0] r2_4;
  // stage 5
  rsi_pkg::front_out_t res5;

  logic signed [43:0] tca26;
  logic signed [43:0] tca26_rnd;
  logic signed [57:0] d2;
  logic               miss_c;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  assign tca26 = 44'(pdx) + 44'(pdy) + 44'(pdz);
  assign tca26_rnd = tca26 + 44'sd8192;
  assign d2 = $signed({6'b0, ll4}) - tca2;
  assign miss_c = d2 > $signed({12'b0, r2_4});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ray1 <= in_data;
      lx   <= 25'(cfg.center_x) - 25'(in_data.origin_x);
      ly   <= 25'(cfg.center_y) - 25'(in_data.origin_y);
      lz   <= 25'(cfg.center_z) - 25'(in_data.origin_z);
      rad1 <= cfg.sphere_radius;
    end
    if (rdy2) begin
      ray2 <= ray1;
      pdx  <= lx * ray1.dir_x;
      pdy  <= ly * ray1.dir_y;
      pdz  <= lz * ray1.dir_z;
      plx  <= lx * lx;
      ply  <= ly * ly;
      plz  <= lz * lz;
      r2_2 <= 46'(rad1) * 46'(rad1);
    end
    if (rdy3) begin
      ray3 <= ray2;
      tca3 <= tca26_rnd[42:14];
      ll3  <= 52'(plx[49:0]) + 52'(ply[49:0]) + 52'(plz[49:0]);
      r2_3 <= r2_2;
    end
    if (rdy4) begin
      ray4 <= ray3;
      tca4 <= tca3;
      tca2 <= 58'(tca3) * 58'(tca3);
      ll4  <= ll3;
      r2_4 <= r2_3;
    end
    if (rdy5) begin
      res5.mid.ray  <= ray4;
      res5.mid.tca  <= tca4;
      res5.mid.miss <= miss_c;
      res5.rem      <= miss_c ? '0 : rsi_pkg::REM_W'($signed({12'b0, r2_4}) - d2);
    end
  end

  assign out_valid = v5;
  assign out_data  = res5;

endmodule

/* sv/rsi_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsi_pkg::front_out_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsi_pkg::sqrt_out_t  out_data
);

  localparam int Stages = rsi_pkg::SQRT_BITS;
  localparam int XW     = rsi_pkg::REM_W;
  localparam int RW     = XW + 1;

  logic              v   [Stages];
  logic              rdy [Stages+1];
  logic [XW-1:0]     x   [Stages];
  logic [RW-1:0]     res [Stages];
  rsi_pkg::mid_t     mid [Stages];

  assign rdy[Stages] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam int Shift = 2 * (Stages - 1 - i);
    logic [XW-1:0] x_in;
    logic [RW-1:0] res_in;
    logic          v_in;
    rsi_pkg::mid_t mid_in;
    logic [RW-1:0] trial;
    logic [XW-1:0] x_nx;
    logic [RW-1:0] res_nx;

    if (i == 0) begin : g_first
      assign x_in   = in_data.rem;
      assign res_in = '0;
      assign v_in   = in_valid;
      assign mid_in = in_data.mid;
    end else begin : g_rest
      assign x_in   = x[i-1];
      assign res_in = res[i-1];
      assign v_in   = v[i-1];
      assign mid_in = mid[i-1];
    end

    assign rdy[i] = !v[i] || rdy[i+1];

    always_comb begin
      trial = res_in + (RW'(1) << Shift);
      if ({1'b0, x_in} >= trial) begin
        x_nx   = x_in - trial[XW-1:0];
        res_nx = (res_in >> 1) + (RW'(1) << Shift);
      end else begin
        x_nx   = x_in;
        res_nx = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        x[i]   <= x_nx;
        res[i] <= res_nx;
        mid[i] <= mid_in;
      end
    end
  end

  assign out_valid    = v[Stages-1];
  assign out_data.mid = mid[Stages-1];
  assign out_data.thc = res[Stages-1][Stages-1:0];

endmodule

/* sv/rsi_back.sv */
// Back pipeline: t, hit point with rounding and saturation, output register.
`include "ray_sphere_intersection_core_defines.svh"

module rsi_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsi_pkg::sqrt_out_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsi_pkg::ray_out_t  out_data
);

  localparam logic signed [32:0] PMax = 33'sd8388607;
  localparam logic signed [32:0] PMin = -33'sd8388608;
  localparam logic [24:0]        DMax = 25'd33554431;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  rsi_pkg::ray_in_t   ray1, ray2;
  logic signed [29:0] t1, t2;
  logic               miss1, miss2;
  logic signed [45:0] td_x, td_y, td_z;
  rsi_pkg::ray_out_t  res3;

  logic signed [29:0] t_c;
  logic signed [45:0] rx, ry, rz;
  logic signed [32:0] sx, sy, sz;

  function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
    if (v > PMax) return 24'sd8388607;
    if (v < PMin) return -24'sd8388608;
    return v[23:0];
  endfunction

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  assign t_c = 30'(in_data.mid.tca) - $signed({2'b0, in_data.thc});

  // round half up at the binary point, then add the origin
  assign rx = td_x + 46'sd8192;
  assign ry = td_y + 46'sd8192;
  assign rz = td_z + 46'sd8192;
  assign sx = 33'(ray2.origin_x) + 33'($signed(rx[45:14]));
  assign sy = 33'(ray2.origin_y) + 33'($signed(ry[45:14]));
  assign sz = 33'(ray2.origin_z) + 33'($signed(rz[45:14]));

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ray1  <= in_data.mid.ray;
      t1    <= t_c;
      miss1 <= in_data.mid.miss || t_c[29];
    end
    if (rdy2) begin
      ray2  <= ray1;
      t2    <= t1;
      miss2 <= miss1;
      td_x  <= t1 * ray1.dir_x;
      td_y  <= t1 * ray1.dir_y;
      td_z  <= t1 * ray1.dir_z;
    end
    if (rdy3) begin
      if (miss2) begin
        res3 <= '0;
      end else begin
        res3.hit      <= 1'b1;
        res3.point_x  <= sat24(sx);
        res3.point_y  <= sat24(sy);
        res3.point_z  <= sat24(sz);
        res3.distance <= (t2 > $signed({5'b0, DMax})) ? DMax : t2[24:0];
      end
    end
  end

  assign out_valid = v3;
  assign out_data  = res3;

  `RSI_ASSERT_NOW(a_miss_zero, out_valid && !out_data.hit, out_data.distance == '0 && out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0, "miss beat carries non-zero payload")
  `RSI_ASSERT_NOW(a_t_front, v1 && !miss1, !t1[29], "hit kept with negative t")
  `RSI_ASSERT_NEXT(a_stall_hold, v2 && !rdy2, v2 && $stable(td_x) && $stable(t2) && $stable(miss2), "stalled stage lost its contents")

endmodule

/* sv/ray_sphere_intersection_core.sv */
// Top level of the ray-sphere intersection core with its register port.
// One ray (origin, unit direction) enters per beat and one result beat leaves
// for every ray: hit flag, hit point and distance, all zero on a miss. The core
// is fully pipelined and takes a new ray every cycle unless a full pipeline is
// held by out_ready; a ray passes through 36 register stages: 5 front stages
// (L vector, products, sums and tca rounding, tca squared, d2 and the miss
// test), 28 square root stages (one root bit per stage over the 56 bit
// remainder) and 3 back stages (t, t times direction, rounding, saturation and
// the output register). Every stage holds its own valid bit and stalls only
// when the stage after it is full, so bubbles close up and input beats are
// still taken while a finished result waits at the output. Registers sit at
// byte addresses 0, 4, 8 and 12: centre x, y, z (signed Q12.12) and radius
// (unsigned Q11.12, reset 25.0). Write them only while no ray is in flight.
module ray_sphere_intersection_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsi_pkg::ray_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsi_pkg::ray_out_t out_data
);

  rsi_pkg::cfg_t      cfg;
  rsi_pkg::reg_idx_t  reg_idx;
  logic               wr_en;

  logic                f_valid, f_ready;
  rsi_pkg::front_out_t f_data;
  logic                s_valid, s_ready;
  rsi_pkg::sqrt_out_t  s_data;

  assign pready  = 1'b1;
  assign reg_idx = rsi_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  // register write in the access phase; upper data bits drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.center_z      <= '0;
      cfg.sphere_radius <= 23'd102400;
    end else if (wr_en) begin
      unique case (reg_idx)
        rsi_pkg::REG_CENTER_X:      cfg.center_x      <= pwdata[23:0];
        rsi_pkg::REG_CENTER_Y:      cfg.center_y      <= pwdata[23:0];
        rsi_pkg::REG_CENTER_Z:      cfg.center_z      <= pwdata[23:0];
        rsi_pkg::REG_SPHERE_RADIUS: cfg.sphere_radius <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // read back the stored bits, zero above
  always_comb begin
    unique case (reg_idx)
      rsi_pkg::REG_CENTER_X:      prdata = {8'b0, cfg.center_x};
      rsi_pkg::REG_CENTER_Y:      prdata = {8'b0, cfg.center_y};
      rsi_pkg::REG_CENTER_Z:      prdata = {8'b0, cfg.center_z};
      rsi_pkg::REG_SPHERE_RADIUS: prdata = {9'b0, cfg.sphere_radius};
      default:                    prdata = '0;
    endcase
  end

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  rsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
